FILE: rtl/handshake_association_table_macros.svh
// Assertion macros used by the checker file hat_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef HANDSHAKE_ASSOCIATION_TABLE_MACROS_SVH
`define HANDSHAKE_ASSOCIATION_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HAT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication checked outside reset.
`define HAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

FILE: rtl/hat_pkg.sv
// Shared types and constants for the handshake association table.
// Used by the controller, datapath, top level and checker.
package hat_pkg;

   localparam int unsigned SlotsDefault = 8;
   localparam logic [31:0] TimeoutReset = 32'd30000;

   // Opcodes.
   localparam logic [2:0] OpInit   = 3'd0;
   localparam logic [2:0] OpEcho   = 3'd1;
   localparam logic [2:0] OpRecord = 3'd2;
   localparam logic [2:0] OpSend   = 3'd3;
   localparam logic [2:0] OpRegKey = 3'd4;
   localparam logic [2:0] OpPrefer = 3'd5;
   localparam logic [2:0] OpClear  = 3'd6;
   localparam logic [2:0] OpNone   = 3'd7;

   // Result status codes.
   localparam logic [2:0] StOk     = 3'd0;
   localparam logic [2:0] StNoSlot = 3'd1;
   localparam logic [2:0] StNoAssoc = 3'd2;
   localparam logic [2:0] StCheck  = 3'd3;
   localparam logic [2:0] StReject = 3'd4;

   // Slot stages.
   localparam logic [1:0] StageAbsent = 2'd0;
   localparam logic [1:0] StageWait   = 2'd1;
   localparam logic [1:0] StageEst    = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [63:0] assoc_id;
      logic [15:0] remote_tag;
      logic [15:0] new_tag;
      logic [63:0] now_ms;
      logic        check_ok;
      logic        sent_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [15:0] requester_tag;
      logic [15:0] responder_tag;
      logic [31:0] send_sequence;
      logic        registered_key;
      logic        last;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;    // capture the request and reset scan state
      logic scan;    // evaluate one slot and preference entry
      logic commit;  // apply the update and build the result
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_last;  // the entry being scanned is the last one
   } sts_type;

endpackage

FILE: rtl/hat_ctrl.sv
// Controller for the handshake association table: sequences load, scan and commit.
// Depends on hat_pkg.
module hat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  hat_pkg::sts_type  sts,
   output hat_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE   = 3'b001,
      SCAN   = 3'b010,
      COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Input is taken only in idle; a waiting result holds the commit instead.
   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = COMMIT;
            end
         end
         COMMIT: begin
            // The result register must be empty or leaving before it is reloaded.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/hat_dpath.sv
// Datapath for the handshake association table: slot and preference tables,
// one-entry-per-cycle scan and the commit update. Depends on hat_pkg.
module hat_dpath #(
   parameter int unsigned SLOTS = hat_pkg::SlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [31:0]       csr_data,
   input  hat_pkg::req_type  req_data,
   input  hat_pkg::cmd_type  cmd,
   output hat_pkg::sts_type  sts,
   output hat_pkg::rsp_type  rsp_data
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Association table.
   logic [1:0]  stage_ff  [SLOTS];
   logic [31:0] addr_ff   [SLOTS];
   logic [15:0] port_ff   [SLOTS];
   logic [63:0] sec_ff    [SLOTS];
   logic [15:0] ptag_ff   [SLOTS];
   logic [15:0] otag_ff   [SLOTS];
   logic [31:0] seq_ff    [SLOTS];
   logic [63:0] touch_ff  [SLOTS];
   logic [63:0] open_ff   [SLOTS];
   logic [63:0] heard_ff  [SLOTS];
   // Preference table.
   logic [31:0] paddr_ff  [SLOTS];
   logic [15:0] pport_ff  [SLOTS];
   logic [63:0] pid_ff    [SLOTS];
   logic [2:0]  pflag_ff  [SLOTS];
   logic [63:0] order_ff;
   logic [31:0] timeout_ff;

   hat_pkg::req_type req_ff;
   hat_pkg::rsp_type rsp_ff, rsp_in;

   // Scan state.
   logic [IW-1:0] idx_ff;
   logic          match_v_ff, spare_v_ff, old_v_ff, rec_v_ff, snd_v_ff;
   logic [IW-1:0] match_ff, spare_ff, old_ff, rec_ff, snd_ff;
   logic          pf_v_ff, pfree_v_ff;
   logic [IW-1:0] pf_ff, pfree_ff;
   logic [SLOTS-1:0] regclr_ff;

   // Current entry compares.
   logic          ep, full, est, pvalid;
   logic [63:0]   age;
   assign ep   = addr_ff[idx_ff] == req_ff.peer_address && port_ff[idx_ff] == req_ff.peer_port;
   assign full = stage_ff[idx_ff] != hat_pkg::StageAbsent && ep
                 && sec_ff[idx_ff] == req_ff.assoc_id;
   assign est  = stage_ff[idx_ff] == hat_pkg::StageEst;
   assign age  = req_ff.now_ms - touch_ff[idx_ff];
   assign pvalid = pflag_ff[idx_ff][0] && paddr_ff[idx_ff] == req_ff.peer_address
                   && pport_ff[idx_ff] == req_ff.peer_port;

   assign sts.scan_last = idx_ff == IW'(SLOTS - 1);

   // The preference lookup runs in the same pass; the preferred-sender test
   // needs the preference entry, so it is recorded per slot and resolved at commit
   // by keeping the first candidate slot whose id equals the preference entry's id.
   logic [SLOTS-1:0] pcand_ff;  // established, endpoint match, heard nonzero

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         idx_ff <= '0;
         {match_v_ff, spare_v_ff, old_v_ff, rec_v_ff, snd_v_ff} <= '0;
         {pf_v_ff, pfree_v_ff} <= '0;
         regclr_ff <= '0;
         pcand_ff  <= '0;
      end else if (cmd.scan) begin
         idx_ff <= sts.scan_last ? '0 : idx_ff + 1'b1;
         if (full && !match_v_ff) begin
            match_v_ff <= 1'b1;
            match_ff   <= idx_ff;
         end
         regclr_ff[idx_ff] <= full;
         if (!spare_v_ff && (stage_ff[idx_ff] == hat_pkg::StageAbsent ||
             (stage_ff[idx_ff] == hat_pkg::StageWait && age > {32'd0, timeout_ff}))) begin
            spare_v_ff <= 1'b1;
            spare_ff   <= idx_ff;
         end
         if (est && (!old_v_ff || touch_ff[idx_ff] < touch_ff[old_ff])) begin
            old_v_ff <= 1'b1;
            old_ff   <= idx_ff;
         end
         if (est && ep && otag_ff[idx_ff] == req_ff.remote_tag && !rec_v_ff) begin
            rec_v_ff <= 1'b1;
            rec_ff   <= idx_ff;
         end
         if (est && ep && (!snd_v_ff || heard_ff[idx_ff] > heard_ff[snd_ff] ||
             (heard_ff[idx_ff] == heard_ff[snd_ff] && open_ff[idx_ff] > open_ff[snd_ff]))) begin
            snd_v_ff <= 1'b1;
            snd_ff   <= idx_ff;
         end
         pcand_ff[idx_ff] <= est && ep && heard_ff[idx_ff] != 64'd0;
         if (pvalid && !pf_v_ff) begin
            pf_v_ff <= 1'b1;
            pf_ff   <= idx_ff;
         end
         if (!pflag_ff[idx_ff][0] && !pfree_v_ff) begin
            pfree_v_ff <= 1'b1;
            pfree_ff   <= idx_ff;
         end
      end
   end

   // Preferred sender: first candidate slot whose id equals the preference id.
   logic          pref_hit;
   logic [IW-1:0] pref_slot;
   always_comb begin
      pref_hit  = 1'b0;
      pref_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (pcand_ff[i] && sec_ff[i] == pid_ff[pf_ff]) begin
            pref_hit  = 1'b1;
            pref_slot = IW'(i);
         end
      end
      pref_hit = pref_hit && pf_v_ff && pflag_ff[pf_ff][2];
   end

   // Commit decisions.
   logic          use_v;
   logic [IW-1:0] use_s, ptgt;
   logic [15:0]   ntag;
   logic          regkey;
   always_comb begin
      use_v = 1'b0;
      use_s = '0;
      case (req_ff.opcode)
         hat_pkg::OpInit: begin
            use_v = match_v_ff || spare_v_ff || old_v_ff;
            use_s = match_v_ff ? match_ff : (spare_v_ff ? spare_ff : old_ff);
         end
         hat_pkg::OpEcho: begin
            use_v = match_v_ff;
            use_s = match_ff;
         end
         hat_pkg::OpRecord: begin
            use_v = rec_v_ff;
            use_s = rec_ff;
         end
         hat_pkg::OpSend: begin
            use_v = pref_hit || snd_v_ff;
            use_s = pref_hit ? pref_slot : snd_ff;
         end
         default: begin
            use_v = 1'b0;
         end
      endcase
      ptgt   = pf_v_ff ? pf_ff : (pfree_v_ff ? pfree_ff : '0);
      ntag   = (req_ff.new_tag == 16'd0) ? 16'd1 : req_ff.new_tag;
      regkey = pf_v_ff && pflag_ff[pf_ff][1] && pid_ff[pf_ff] == sec_ff[match_ff];
   end

   // Result built from the pre-update table state, with updated tags on init.
   always_comb begin
      rsp_in                = '0;
      rsp_in.last           = 1'b1;
      rsp_in.status         = hat_pkg::StReject;
      case (req_ff.opcode)
         hat_pkg::OpInit:   rsp_in.status = use_v ? hat_pkg::StOk : hat_pkg::StNoSlot;
         hat_pkg::OpEcho, hat_pkg::OpRecord, hat_pkg::OpSend: begin
            if (!use_v) begin
               rsp_in.status = hat_pkg::StNoAssoc;
            end else if (!req_ff.check_ok) begin
               rsp_in.status = hat_pkg::StCheck;
            end else if (req_ff.opcode == hat_pkg::OpEcho && !req_ff.sent_ok) begin
               rsp_in.status = hat_pkg::StReject;
            end else begin
               rsp_in.status = hat_pkg::StOk;
            end
         end
         hat_pkg::OpRegKey, hat_pkg::OpPrefer: begin
            rsp_in.status = (req_ff.assoc_id != 64'd0) ? hat_pkg::StOk : hat_pkg::StReject;
         end
         hat_pkg::OpClear:  rsp_in.status = hat_pkg::StOk;
         default:           rsp_in.status = hat_pkg::StReject;
      endcase
      if (use_v) begin
         rsp_in.slot          = 3'(use_s);
         rsp_in.requester_tag = (req_ff.opcode == hat_pkg::OpInit) ? req_ff.remote_tag
                                                                   : ptag_ff[use_s];
         rsp_in.responder_tag = (req_ff.opcode == hat_pkg::OpInit) ? ntag : otag_ff[use_s];
      end
      if (req_ff.opcode == hat_pkg::OpSend && use_v && req_ff.check_ok) begin
         rsp_in.send_sequence = seq_ff[use_s];
      end
      if (req_ff.opcode == hat_pkg::OpEcho && use_v && req_ff.check_ok) begin
         rsp_in.registered_key = regkey;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end
   assign rsp_data = rsp_ff;

   // Table updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= hat_pkg::TimeoutReset;
      end else if (csr_write) begin
         timeout_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.commit && req_ff.opcode == hat_pkg::OpClear)) begin
         order_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            stage_ff[i] <= hat_pkg::StageAbsent;
            addr_ff[i]  <= '0;  port_ff[i]  <= '0;  sec_ff[i]   <= '0;
            ptag_ff[i]  <= '0;  otag_ff[i]  <= '0;  seq_ff[i]   <= '0;
            touch_ff[i] <= '0;  open_ff[i]  <= '0;  heard_ff[i] <= '0;
            paddr_ff[i] <= '0;  pport_ff[i] <= '0;  pid_ff[i]   <= '0;
            pflag_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         case (req_ff.opcode)
            hat_pkg::OpInit: begin
               if (use_v) begin
                  stage_ff[use_s] <= hat_pkg::StageWait;
                  addr_ff[use_s]  <= req_ff.peer_address;
                  port_ff[use_s]  <= req_ff.peer_port;
                  sec_ff[use_s]   <= req_ff.assoc_id;
                  ptag_ff[use_s]  <= req_ff.remote_tag;
                  otag_ff[use_s]  <= ntag;
                  seq_ff[use_s]   <= 32'd1;
                  touch_ff[use_s] <= req_ff.now_ms;
                  open_ff[use_s]  <= '0;
                  heard_ff[use_s] <= '0;
               end
            end
            hat_pkg::OpEcho: begin
               if (use_v && req_ff.check_ok) begin
                  touch_ff[use_s] <= req_ff.now_ms;
                  if (req_ff.sent_ok) begin
                     stage_ff[use_s] <= hat_pkg::StageEst;
                     order_ff        <= order_ff + 64'd1;
                     open_ff[use_s]  <= order_ff + 64'd1;
                  end else begin
                     stage_ff[use_s] <= hat_pkg::StageWait;
                  end
               end
            end
            hat_pkg::OpRecord: begin
               if (use_v && req_ff.check_ok) begin
                  touch_ff[use_s] <= req_ff.now_ms;
                  order_ff        <= order_ff + 64'd1;
                  heard_ff[use_s] <= order_ff + 64'd1;
               end
            end
            hat_pkg::OpSend: begin
               if (use_v && req_ff.check_ok) begin
                  seq_ff[use_s] <= seq_ff[use_s] + 32'd1;
               end
            end
            hat_pkg::OpRegKey: begin
               if (req_ff.assoc_id != 64'd0) begin
                  paddr_ff[ptgt] <= req_ff.peer_address;
                  pport_ff[ptgt] <= req_ff.peer_port;
                  pid_ff[ptgt]   <= req_ff.assoc_id;
                  pflag_ff[ptgt] <= 3'b011;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (regclr_ff[i]) begin
                        stage_ff[i] <= hat_pkg::StageAbsent;
                        addr_ff[i]  <= '0;  port_ff[i]  <= '0;  sec_ff[i]   <= '0;
                        ptag_ff[i]  <= '0;  otag_ff[i]  <= '0;  seq_ff[i]   <= '0;
                        touch_ff[i] <= '0;  open_ff[i]  <= '0;  heard_ff[i] <= '0;
                     end
                  end
               end
            end
            hat_pkg::OpPrefer: begin
               if (req_ff.assoc_id != 64'd0) begin
                  if (!pflag_ff[ptgt][0] || pid_ff[ptgt] != req_ff.assoc_id) begin
                     paddr_ff[ptgt] <= req_ff.peer_address;
                     pport_ff[ptgt] <= req_ff.peer_port;
                     pid_ff[ptgt]   <= req_ff.assoc_id;
                     pflag_ff[ptgt] <= 3'b101;
                  end else begin
                     pflag_ff[ptgt] <= pflag_ff[ptgt] | 3'b100;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: rtl/handshake_association_table.sv
// Handshake association table top level: controller plus datapath.
// An input transfer starts a scan over every table entry, then a commit loads
// the result register; the next input is taken only back in idle, after the commit.
// A stalled result waits in the output register and holds the next commit.
// Synchronous active-high reset empties both tables and loads the timeout with 30000.
module handshake_association_table #(
   parameter int unsigned SLOTS = hat_pkg::SlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hat_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hat_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [31:0]       csr_data
);

   hat_pkg::cmd_type cmd;
   hat_pkg::sts_type sts;

   hat_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   hat_dpath #(.SLOTS(SLOTS)) u_dpath (
      .clock, .reset, .csr_write, .csr_data, .req_data, .cmd, .sts, .rsp_data
   );

endmodule

FILE: rtl/hat_checker.sv
// Port-level checker for the handshake association table, bound to the top level.
// Depends on hat_pkg and handshake_association_table_macros.svh.
`include "handshake_association_table_macros.svh"
module hat_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hat_pkg::rsp_type rsp_data
);

   // Every result is marked last.
   `HAT_ASSERT_IMP(a_last, clock, reset, rsp_valid, rsp_data.last)
   // The block is busy right after an input transfer.
   `HAT_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall)
   // A stalled result stays valid.
   `HAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // A stalled result keeps its payload.
   `HAT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind handshake_association_table hat_checker u_hat_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

FILE: verif/tb.sv
// Testbench for the handshake association table: drives opcode transfers,
// predicts each result from a behavioral table model and checks it.
// Depends on hat_pkg and the handshake_association_table top level.
`timescale 1ns / 100ps

// Scoreboard: keeps the predicted table state and the pending results.
class association_scoreboard;
   logic [31:0] timeout_ms;
   logic [1:0]  stage [8];
   logic [31:0] addr_q [8];
   logic [15:0] port_q [8];
   logic [63:0] sec_q [8];
   logic [15:0] ptag_q [8];
   logic [15:0] otag_q [8];
   logic [31:0] seq_q [8];
   logic [63:0] touched [8];
   logic [63:0] opened [8];
   logic [63:0] heard [8];
   logic [31:0] paddr [8];
   logic [15:0] pport [8];
   logic [63:0] pid [8];
   logic [2:0]  pflags [8];
   logic [63:0] order_clock;
   hat_pkg::rsp_type pending_results[$];
   int errors;

   function new();
      timeout_ms = hat_pkg::TimeoutReset;
      errors = 0;
      clear_tables();
   endfunction

   function void clear_slot(int i);
      stage[i] = hat_pkg::StageAbsent;
      addr_q[i] = 0; port_q[i] = 0; sec_q[i] = 0; ptag_q[i] = 0; otag_q[i] = 0;
      seq_q[i] = 0; touched[i] = 0; opened[i] = 0; heard[i] = 0;
   endfunction

   function void clear_tables();
      for (int i = 0; i < 8; i++) begin
         clear_slot(i);
         paddr[i] = 0; pport[i] = 0; pid[i] = 0; pflags[i] = 0;
      end
      order_clock = 0;
   endfunction

   function int pref_find(logic [31:0] a, logic [15:0] p);
      for (int i = 0; i < 8; i++)
         if (pflags[i][0] && paddr[i] == a && pport[i] == p) return i;
      return -1;
   endfunction

   function int pref_target(logic [31:0] a, logic [15:0] p);
      int t;
      t = pref_find(a, p);
      if (t >= 0) return t;
      for (int i = 0; i < 8; i++)
         if (!pflags[i][0]) return i;
      return 0;
   endfunction

   function bit same_assoc(int i, logic [31:0] a, logic [15:0] p, logic [63:0] id);
      return stage[i] != hat_pkg::StageAbsent && addr_q[i] == a && port_q[i] == p
         && sec_q[i] == id;
   endfunction

   // Predicts the result of one accepted request and updates the tables.
   function void note_request(hat_pkg::req_type r);
      hat_pkg::rsp_type e;
      int s, spare, oldest, pr;
      logic [63:0] age;
      s = -1; spare = -1; oldest = -1;
      e = '0;
      e.status = hat_pkg::StReject;
      e.last = 1'b1;
      case (r.opcode)
         hat_pkg::OpInit: begin
            for (int i = 0; i < 8 && s < 0; i++) begin
               age = r.now_ms - touched[i];
               if (same_assoc(i, r.peer_address, r.peer_port, r.assoc_id)) s = i;
               else begin
                  if (spare < 0 && (stage[i] == hat_pkg::StageAbsent ||
                      (stage[i] == hat_pkg::StageWait && age > {32'd0, timeout_ms})))
                     spare = i;
                  if (stage[i] == hat_pkg::StageEst &&
                      (oldest < 0 || touched[i] < touched[oldest]))
                     oldest = i;
               end
            end
            if (s < 0) s = (spare >= 0) ? spare : oldest;
            if (s < 0) e.status = hat_pkg::StNoSlot;
            else begin
               clear_slot(s);
               stage[s] = hat_pkg::StageWait;
               addr_q[s] = r.peer_address; port_q[s] = r.peer_port;
               sec_q[s] = r.assoc_id; ptag_q[s] = r.remote_tag;
               otag_q[s] = (r.new_tag == 0) ? 16'd1 : r.new_tag;
               seq_q[s] = 1; touched[s] = r.now_ms;
               e.status = hat_pkg::StOk;
            end
         end
         hat_pkg::OpEcho: begin
            for (int i = 0; i < 8 && s < 0; i++)
               if (same_assoc(i, r.peer_address, r.peer_port, r.assoc_id)) s = i;
            if (s < 0) e.status = hat_pkg::StNoAssoc;
            else if (!r.check_ok) e.status = hat_pkg::StCheck;
            else begin
               pr = pref_find(r.peer_address, r.peer_port);
               touched[s] = r.now_ms;
               e.registered_key = (pr >= 0 && pflags[pr][1] && pid[pr] == sec_q[s]);
               if (r.sent_ok) begin
                  stage[s] = hat_pkg::StageEst;
                  order_clock++;
                  opened[s] = order_clock;
                  e.status = hat_pkg::StOk;
               end else begin
                  stage[s] = hat_pkg::StageWait;
                  e.status = hat_pkg::StReject;
               end
            end
         end
         hat_pkg::OpRecord: begin
            for (int i = 0; i < 8 && s < 0; i++)
               if (stage[i] == hat_pkg::StageEst && addr_q[i] == r.peer_address &&
                   port_q[i] == r.peer_port && otag_q[i] == r.remote_tag) s = i;
            if (s < 0) e.status = hat_pkg::StNoAssoc;
            else if (!r.check_ok) e.status = hat_pkg::StCheck;
            else begin
               touched[s] = r.now_ms;
               order_clock++;
               heard[s] = order_clock;
               e.status = hat_pkg::StOk;
            end
         end
         hat_pkg::OpSend: begin
            pr = pref_find(r.peer_address, r.peer_port);
            for (int i = 0; i < 8; i++) begin
               if (stage[i] != hat_pkg::StageEst || addr_q[i] != r.peer_address ||
                   port_q[i] != r.peer_port) continue;
               if (pr >= 0 && pflags[pr][2] && heard[i] != 0 && sec_q[i] == pid[pr]) begin
                  s = i;
                  break;
               end
               if (s < 0 || heard[i] > heard[s] ||
                   (heard[i] == heard[s] && opened[i] > opened[s])) s = i;
            end
            if (s < 0) e.status = hat_pkg::StNoAssoc;
            else if (!r.check_ok) e.status = hat_pkg::StCheck;
            else begin
               e.send_sequence = seq_q[s];
               seq_q[s] = seq_q[s] + 32'd1;
               e.status = hat_pkg::StOk;
            end
         end
         hat_pkg::OpRegKey: if (r.assoc_id != 0) begin
            pr = pref_target(r.peer_address, r.peer_port);
            paddr[pr] = r.peer_address; pport[pr] = r.peer_port;
            pid[pr] = r.assoc_id; pflags[pr] = 3'b011;
            for (int i = 0; i < 8; i++)
               if (same_assoc(i, r.peer_address, r.peer_port, r.assoc_id)) clear_slot(i);
            e.status = hat_pkg::StOk;
         end
         hat_pkg::OpPrefer: if (r.assoc_id != 0) begin
            pr = pref_target(r.peer_address, r.peer_port);
            if (!pflags[pr][0] || pid[pr] != r.assoc_id) begin
               paddr[pr] = r.peer_address; pport[pr] = r.peer_port;
               pid[pr] = r.assoc_id; pflags[pr] = 3'b001;
            end
            pflags[pr][2] = 1'b1;
            e.status = hat_pkg::StOk;
         end
         hat_pkg::OpClear: begin
            clear_tables();
            e.status = hat_pkg::StOk;
         end
         default: ;
      endcase
      if (s >= 0 && r.opcode <= hat_pkg::OpSend) begin
         e.slot = s[2:0];
         e.requester_tag = ptag_q[s];
         e.responder_tag = otag_q[s];
      end
      pending_results.push_back(e);
   endfunction

   // Compares one accepted result with the oldest prediction.
   function void check_result(hat_pkg::rsp_type got);
      hat_pkg::rsp_type e;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result %p", $time, got);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status)
         $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
      if (got.slot !== e.slot)
         $display("%0t: slot expected %0d actual %0d", $time, e.slot, got.slot);
      if (got.requester_tag !== e.requester_tag)
         $display("%0t: requester_tag expected %h actual %h", $time,
                  e.requester_tag, got.requester_tag);
      if (got.responder_tag !== e.responder_tag)
         $display("%0t: responder_tag expected %h actual %h", $time,
                  e.responder_tag, got.responder_tag);
      if (got.send_sequence !== e.send_sequence)
         $display("%0t: send_sequence expected %h actual %h", $time,
                  e.send_sequence, got.send_sequence);
      if (got.registered_key !== e.registered_key)
         $display("%0t: registered_key expected %0d actual %0d", $time,
                  e.registered_key, got.registered_key);
      if (got.last !== e.last)
         $display("%0t: last expected %0d actual %0d", $time, e.last, got.last);
      if (got !== e) errors++;
   endfunction
endclass

module tb;
   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   hat_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   hat_pkg::rsp_type rsp_data;
   logic csr_write;
   logic [31:0] csr_data;

   association_scoreboard board;
   int cycle_count;
   bit rsp_idle_ok;
   bit hold_off;
   logic [63:0] tick;
   logic [31:0] endpoint_addr [4];
   logic [15:0] endpoint_port [4];
   logic [63:0] endpoint_id [4];

   handshake_association_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result checking at each accepted transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Receiver stalls: random bursts, one long hold-off, none at the end.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else if (rsp_idle_ok && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request and waits for its transfer.
   task automatic send_request(hat_pkg::req_type r, bit gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   // Withdraws the last offer and waits for every result.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] v);
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      board.timeout_ms = v;
   endtask

   // Builds a request aimed at a small endpoint pool so that sequences connect.
   function automatic hat_pkg::req_type pooled_request(logic [2:0] op);
      hat_pkg::req_type r;
      int k;
      k = $urandom_range(0, 3);
      r.opcode = op;
      r.peer_address = endpoint_addr[k];
      r.peer_port = endpoint_port[k];
      r.assoc_id = ($urandom_range(0, 3) == 0) ? endpoint_id[$urandom_range(0, 3)]
                                                : endpoint_id[k];
      r.remote_tag = 16'($urandom_range(0, 3));
      r.new_tag = 16'($urandom_range(0, 3));
      tick = tick + 64'($urandom_range(0, 20000));
      r.now_ms = tick;
      r.check_ok = ($urandom_range(0, 7) != 0);
      r.sent_ok = ($urandom_range(0, 5) != 0);
      return r;
   endfunction

   function automatic hat_pkg::req_type noise_request();
      hat_pkg::req_type r;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(hat_pkg::req_type)-1:0];
      return r;
   endfunction

   initial begin
      hat_pkg::req_type r;
      logic [31:0] tmo;
      board = new();
      cycle_count = 0;
      rsp_idle_ok = 1'b0;
      hold_off = 1'b0;
      tick = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_data = '0;
      for (int i = 0; i < 4; i++) begin
         endpoint_addr[i] = (i == 3) ? 32'hFFFFFFFF : $urandom;
         endpoint_port[i] = (i == 3) ? 16'hFFFF : 16'($urandom);
         endpoint_id[i] = (i == 0) ? 64'hFFFFFFFFFFFFFFFF : {$urandom, $urandom};
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full handshake, record, send, preferences, rejects and clear.
      r = '0;
      r.peer_address = endpoint_addr[0]; r.peer_port = endpoint_port[0];
      r.assoc_id = endpoint_id[0]; r.remote_tag = 16'hFFFF; r.new_tag = 0;
      r.now_ms = 64'd100; r.check_ok = 1; r.sent_ok = 1;
      r.opcode = hat_pkg::OpInit;   send_request(r, 0);
      r.opcode = hat_pkg::OpSend;   send_request(r, 0);
      r.opcode = hat_pkg::OpEcho;   r.check_ok = 0; send_request(r, 0);
      r.check_ok = 1; r.sent_ok = 0; send_request(r, 0);
      r.sent_ok = 1; send_request(r, 0);
      r.opcode = hat_pkg::OpRecord; r.remote_tag = 16'd1; send_request(r, 0);
      r.check_ok = 0; send_request(r, 0);
      r.remote_tag = 16'd7; r.check_ok = 1; send_request(r, 0);
      r.opcode = hat_pkg::OpSend;   send_request(r, 0);
      r.check_ok = 0; send_request(r, 0);
      r.check_ok = 1;
      r.opcode = hat_pkg::OpPrefer; send_request(r, 0);
      r.opcode = hat_pkg::OpSend;   send_request(r, 0);
      r.assoc_id = 0;
      r.opcode = hat_pkg::OpPrefer; send_request(r, 0);
      r.opcode = hat_pkg::OpRegKey; send_request(r, 0);
      r.assoc_id = endpoint_id[0]; send_request(r, 0);
      r.opcode = hat_pkg::OpInit;   r.now_ms = 64'hFFFFFFFFFFFFFFFF; send_request(r, 0);
      r.opcode = hat_pkg::OpEcho;   send_request(r, 0);
      r.opcode = hat_pkg::OpNone;   send_request(r, 0);
      // Fill every slot so that a further init finds none.
      for (int i = 0; i < 9; i++) begin
         r = noise_request();
         r.opcode = hat_pkg::OpInit; r.now_ms = 64'd0;
         send_request(r, 0);
      end
      r.opcode = hat_pkg::OpClear;  send_request(r, 0);
      drain();

      // Random phases across several timeout settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: tmo = 32'd0;
            1: tmo = 32'hFFFFFFFF;
            default: tmo = $urandom_range(0, 60000);
         endcase
         write_timeout(tmo);
         rsp_idle_ok = (phase < 5);
         if (phase == 2) hold_off = 1'b1;
         for (int n = 0; n < 280; n++) begin
            if ($urandom_range(0, 19) == 0) r = noise_request();
            else begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4:  r = pooled_request(hat_pkg::OpInit);
                  5, 6, 7, 8, 9:  r = pooled_request(hat_pkg::OpEcho);
                  10, 11, 12:     r = pooled_request(hat_pkg::OpRecord);
                  13, 14, 15:     r = pooled_request(hat_pkg::OpSend);
                  16:             r = pooled_request(hat_pkg::OpRegKey);
                  17, 18:         r = pooled_request(hat_pkg::OpPrefer);
                  default:        r = pooled_request(($urandom_range(0, 3) == 0)
                                                     ? hat_pkg::OpClear : hat_pkg::OpNone);
               endcase
               // Records usually name a tag that the slot actually carries.
               if (r.opcode == hat_pkg::OpRecord && $urandom_range(0, 2) != 0)
                  r.remote_tag = board.otag_q[$urandom_range(0, 7)];
            end
            send_request(r, phase < 5);
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/hat_pkg.sv
rtl/hat_ctrl.sv
rtl/hat_dpath.sv
rtl/handshake_association_table.sv
rtl/hat_checker.sv
verif/tb.sv
